### src/vectorscope_accumulator_defines.svh
// Assertion macros for the vectorscope accumulator.
`ifndef VECTORSCOPE_ACCUMULATOR_DEFINES_SVH
`define VECTORSCOPE_ACCUMULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, clocked on clk and quiet during reset
`define VSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vectorscope_accumulator: same-cycle check failed");

// Next-cycle implication, clocked on clk and quiet during reset
`define VSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vectorscope_accumulator: next-cycle check failed");

`else

`define VSA_ASSERT_IMP(lbl, ante, cons)
`define VSA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### src/vsa_pkg.sv
// Shared constants, codes and control types of the vectorscope accumulator.
package vsa_pkg;

    // Default geometry
    localparam int GRID_SIZE_DEF  = 256;
    localparam int COUNT_BITS_DEF = 32;

    // Request codes
    localparam logic [1:0] REQ_ACCUM = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // BT.601 chroma weights in Q16
    localparam int CB_R = 11076;
    localparam int CB_G = 21692;
    localparam int CB_B = 32768;
    localparam int CR_R = 32768;
    localparam int CR_G = 27460;
    localparam int CR_B = 5308;

    // Offset of 140 chroma units in Q16; also the half-step rounding term
    localparam int CHROMA_OFS = 140 * 65536;

    // Chroma after offset fits 25 bits, scaled product 35 bits
    localparam int U_W    = 25;
    localparam int CHR_W  = 27;
    localparam int PROD_W = 35;

    // Divide by 280*2^16 = 35*2^19: shift by 19, then multiply by reciprocal of 35
    localparam int PRE_SHIFT   = 19;
    localparam int T_W         = 15;
    localparam int RECIP       = 59919;
    localparam int RECIP_SHIFT = 21;
    localparam int QMUL_W      = 31;
    localparam int Q_W         = 10;

    // Width used to form a linear cell address
    localparam int LIN_W = 20;

    // Output field width
    localparam int OUT_W = 32;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHROMA,
        ST_SCALE,
        ST_DIV,
        ST_ADDR,
        ST_READ,
        ST_UPDATE,
        ST_RESPOND
    } vsa_state_t;

    typedef struct packed {
        logic capture;
        logic mem_read;
        logic bump;
        logic clear_wr;
        logic load_out;
    } vsa_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       clear_last;
        logic       out_free;
    } vsa_status_t;

endpackage

### src/vsa_ctrl.sv
// Sequencer of the vectorscope accumulator: steps one request through the datapath.
module vsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           req_type,
    output logic                 in_stall,
    input  vsa_pkg::vsa_status_t status,
    output vsa_pkg::vsa_cmd_t    cmd
);
    import vsa_pkg::*;

    vsa_state_t state_reg;
    vsa_state_t state_next;

    // Hold state; reset starts with a sweep of the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the steps of the current request
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_ACCUM: state_next = ST_CHROMA;
                        REQ_READ:  state_next = ST_ADDR;
                        REQ_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CHROMA: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DIV;
            ST_DIV:    state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_READ;
            ST_READ:
            begin
                if (status.req == REQ_READ)
                begin
                    state_next = ST_RESPOND;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_IDLE;
            ST_RESPOND:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands and the input stall
    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        cmd.capture  = (state_reg == ST_IDLE);
        cmd.mem_read = (state_reg == ST_READ);
        cmd.bump     = (state_reg == ST_UPDATE);
        cmd.clear_wr = (state_reg == ST_CLEAR);
        cmd.load_out = (state_reg == ST_RESPOND) && status.out_free;
    end

endmodule

### src/vsa_datapath.sv
// Datapath of the vectorscope accumulator: chroma math, cell store, peak and output beat.
module vsa_datapath #(
    parameter int GRID_SIZE  = vsa_pkg::GRID_SIZE_DEF,
    parameter int COUNT_BITS = vsa_pkg::COUNT_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  vsa_pkg::vsa_cmd_t       cmd,
    output vsa_pkg::vsa_status_t    status,
    input  logic [1:0]              req_type,
    input  logic [7:0]              red,
    input  logic [7:0]              green,
    input  logic [7:0]              blue,
    input  logic [7:0]              cell_x,
    input  logic [7:0]              cell_y,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic [vsa_pkg::OUT_W-1:0] cell_count,
    output logic [vsa_pkg::OUT_W-1:0] peak_count
);
    import vsa_pkg::*;

    localparam int CELLS  = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int POS_W  = $clog2(GRID_SIZE);
    localparam logic [Q_W-1:0]        POS_MAX   = Q_W'(GRID_SIZE - 1);
    localparam logic [Q_W-1:0]        GRID_V    = Q_W'(GRID_SIZE);
    localparam logic [ADDR_W-1:0]     LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Captured request
    logic [1:0] req_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] x_reg;
    logic [7:0] y_reg;

    // Chroma, scale and position stages
    logic [CHR_W-1:0]  ucb_full;
    logic [CHR_W-1:0]  ucr_full;
    logic [U_W-1:0]    ucb_reg;
    logic [U_W-1:0]    ucr_reg;
    logic [PROD_W-1:0] scb_prod;
    logic [PROD_W-1:0] scr_prod;
    logic [T_W-1:0]    tcb_reg;
    logic [T_W-1:0]    tcr_reg;
    logic [QMUL_W-1:0] qcb_prod;
    logic [QMUL_W-1:0] qcr_prod;
    logic [Q_W-1:0]    qcb;
    logic [Q_W-1:0]    qcr;
    logic [POS_W-1:0]  col_reg;
    logic [POS_W-1:0]  row_reg;

    // Address stage
    logic [LIN_W-1:0]  lin_addr;
    logic              in_range;
    logic [ADDR_W-1:0] addr_reg;
    logic              in_range_reg;

    // Store, counters and output
    logic [COUNT_BITS-1:0] bin_mem [CELLS];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic [COUNT_BITS-1:0] bumped;
    logic [COUNT_BITS-1:0] peak_reg;
    logic [ADDR_W-1:0]     clear_idx_reg;
    logic [ADDR_W-1:0]     clear_idx_next;
    logic                  clear_last;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  wr_en;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      cell_count_reg;
    logic [OUT_W-1:0]      peak_count_reg;

    // Latch the request while idle
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            x_reg     <= cell_x;
            y_reg     <= cell_y;
        end
    end

    // Offset Cb and negated Cr; both land in 0..2*CHROMA_OFS, so wrapping math is exact
    always_comb
    begin
        ucb_full = CHR_W'(CHROMA_OFS) + CHR_W'(CB_B) * CHR_W'(blue_reg)
                 - CHR_W'(CB_R) * CHR_W'(red_reg) - CHR_W'(CB_G) * CHR_W'(green_reg);
        ucr_full = CHR_W'(CHROMA_OFS) + CHR_W'(CR_G) * CHR_W'(green_reg)
                 + CHR_W'(CR_B) * CHR_W'(blue_reg) - CHR_W'(CR_R) * CHR_W'(red_reg);
    end

    // Scale onto the grid with half-step rounding, then take the power-of-two part
    always_comb
    begin
        scb_prod = PROD_W'(GRID_SIZE) * PROD_W'(ucb_reg) + PROD_W'(CHROMA_OFS);
        scr_prod = PROD_W'(GRID_SIZE) * PROD_W'(ucr_reg) + PROD_W'(CHROMA_OFS);
    end

    // Divide by 35 through the reciprocal and clamp to the last column or row
    always_comb
    begin
        qcb_prod = QMUL_W'(tcb_reg) * QMUL_W'(RECIP);
        qcr_prod = QMUL_W'(tcr_reg) * QMUL_W'(RECIP);
        qcb      = qcb_prod[QMUL_W-1:RECIP_SHIFT];
        qcr      = qcr_prod[QMUL_W-1:RECIP_SHIFT];
        if (qcb > POS_MAX)
        begin
            qcb = POS_MAX;
        end
        if (qcr > POS_MAX)
        begin
            qcr = POS_MAX;
        end
    end

    // Pick the cell: computed position for a pixel, requested one for a read
    always_comb
    begin
        if (req_reg == REQ_READ)
        begin
            lin_addr = LIN_W'(y_reg) * LIN_W'(GRID_SIZE) + LIN_W'(x_reg);
            in_range = (Q_W'(x_reg) < GRID_V) && (Q_W'(y_reg) < GRID_V);
        end
        else
        begin
            lin_addr = LIN_W'(row_reg) * LIN_W'(GRID_SIZE) + LIN_W'(col_reg);
            in_range = 1'b1;
        end
    end

    // Advance the arithmetic stages; the sequencer holds the request steady meanwhile
    always_ff @(posedge clk)
    begin
        ucb_reg      <= ucb_full[U_W-1:0];
        ucr_reg      <= ucr_full[U_W-1:0];
        tcb_reg      <= scb_prod[PRE_SHIFT+T_W-1:PRE_SHIFT];
        tcr_reg      <= scr_prod[PRE_SHIFT+T_W-1:PRE_SHIFT];
        col_reg      <= POS_W'(qcb);
        row_reg      <= POS_W'(qcr);
        addr_reg     <= ADDR_W'(lin_addr);
        in_range_reg <= in_range;
    end

    // Saturating increment of the fetched count
    assign bumped = (rdata_reg == COUNT_MAX) ? rdata_reg : rdata_reg + 1'b1;

    // Clear sweep position
    assign clear_last     = (clear_idx_reg == LAST_CELL);
    assign clear_idx_next = clear_last ? '0 : clear_idx_reg + 1'b1;

    // One write port: sweep zeros or store the bumped count
    always_comb
    begin
        wr_en   = cmd.clear_wr || cmd.bump;
        wr_addr = cmd.clear_wr ? clear_idx_reg : addr_reg;
        wr_data = cmd.clear_wr ? '0 : bumped;
    end

    // Cell store with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_read)
        begin
            rdata_reg <= bin_mem[addr_reg];
        end
    end

    // Sweep index and peak
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_idx_reg <= '0;
            peak_reg      <= '0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clear_idx_reg <= clear_idx_next;
                peak_reg      <= '0;
            end
            else if (cmd.bump && (bumped > peak_reg))
            begin
                peak_reg <= bumped;
            end
        end
    end

    // Output beat register: load a read result, drop the beat once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            cell_count_reg <= in_range_reg ? OUT_W'(rdata_reg) : '0;
            peak_count_reg <= OUT_W'(peak_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_count = cell_count_reg;
    assign peak_count = peak_count_reg;

    assign status.req        = req_reg;
    assign status.clear_last = clear_last;
    assign status.out_free   = !out_valid_reg || !out_stall;

endmodule

### src/vectorscope_accumulator.sv
// Top level of the vectorscope accumulator: sequencer, datapath and checks.
//
// Input channel (in_valid/in_stall) carries one request per beat: req_type
// 0 adds an RGB pixel to its BT.601 chroma cell, 1 reads cell (cell_y, cell_x),
// 2 clears the grid and peak; code 3 is taken and ignored.
// Output channel (out_valid/out_stall) carries one beat per read request:
// the cell count (zero outside the grid) and the peak count since last clear.
// The block works on one request at a time; a sequencer walks it through
// the datapath and the single-port cell store.
//   accumulate: per pixel the steps chroma, scale, divide, address, read, write
//   read: steps address, read and respond; the next request is taken after respond
//   clear: one store entry zeroed per cycle across all GRID_SIZE*GRID_SIZE entries
// After reset the same sweep of the store runs with in_stall high. A read
// result sits in an output register; while out_stall is high it holds, and a
// further read waits only until that register frees up.
`include "vectorscope_accumulator_defines.svh"

module vectorscope_accumulator #(
    parameter int GRID_SIZE  = vsa_pkg::GRID_SIZE_DEF,
    parameter int COUNT_BITS = vsa_pkg::COUNT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                req_type,
    input  logic [7:0]                red,
    input  logic [7:0]                green,
    input  logic [7:0]                blue,
    input  logic [7:0]                cell_x,
    input  logic [7:0]                cell_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [vsa_pkg::OUT_W-1:0] cell_count,
    output logic [vsa_pkg::OUT_W-1:0] peak_count
);
    import vsa_pkg::*;

    vsa_cmd_t    cmd;
    vsa_status_t status;
    logic        real_req;

    // Sequencer
    vsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, store and output register
    vsa_datapath #(
        .GRID_SIZE  (GRID_SIZE),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .req_type   (req_type),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .cell_count (cell_count),
        .peak_count (peak_count)
    );

    // Flag request codes that start work in the sequencer
    assign real_req = (req_type == REQ_ACCUM) || (req_type == REQ_READ)
                   || (req_type == REQ_CLEAR);

    // A real request keeps the input stalled in the cycle after its accept
    `VSA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall && real_req, in_stall)
    // Store port sees at most one of sweep, fetch and write-back
    `VSA_ASSERT_IMP(a_one_store_op, 1'b1, $onehot0({cmd.mem_read, cmd.bump, cmd.clear_wr}))
    // A result is loaded only when the output register is free
    `VSA_ASSERT_IMP(a_load_when_free, cmd.load_out, !out_valid || !out_stall)

endmodule
